/* sv/i8080alu_pkg.sv */
// ----------------------------------------------------------------------------
// i8080alu_pkg
// Operation codes and flag layout of the 8080-class accumulator/flag unit.
// ----------------------------------------------------------------------------
package i8080alu_pkg;

   typedef enum logic [4:0] {
      OP_ADD = 5'd0,
      OP_ADC = 5'd1,
      OP_SUB = 5'd2,
      OP_SBB = 5'd3,
      OP_ANA = 5'd4,
      OP_XRA = 5'd5,
      OP_ORA = 5'd6,
      OP_CMP = 5'd7,
      OP_RLC = 5'd8,
      OP_RRC = 5'd9,
      OP_RAL = 5'd10,
      OP_RAR = 5'd11,
      OP_DAA = 5'd12,
      OP_CMA = 5'd13,
      OP_STC = 5'd14,
      OP_CMC = 5'd15,
      OP_LDA = 5'd16,
      OP_LDF = 5'd17
   } op_type;

   // internal flag word
   typedef struct packed {
      logic s;
      logic z;
      logic ac;
      logic p;
      logic c;
   } flags_type;

   localparam logic [3:0] LOW_ADJ  = 4'h6;
   localparam logic [7:0] HIGH_ADJ = 8'h60;

   // flag byte: bit7 s, bit6 z, bit4 ac, bit2 p, bit0 c
   function automatic logic [7:0] flags_to_byte(input flags_type f);
      flags_to_byte = {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b0, f.c};
   endfunction

   function automatic flags_type byte_to_flags(input logic [7:0] b);
      byte_to_flags = '{s: b[7], z: b[6], ac: b[4], p: b[2], c: b[0]};
   endfunction

   // nibble value above nine
   function automatic logic above_nine(input logic [3:0] n);
      above_nine = n[3] & (n[2] | n[1]);
   endfunction

endpackage

/* sv/i8080_alu_flags.sv */
// ----------------------------------------------------------------------------
// i8080_alu_flags
// Accumulator and flag unit of an 8080-class CPU.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation item: tuser holds the operation code,
//   tdata the operand byte (second operand, new accumulator or flag byte).
//   rsp channel returns one item per request: the accumulator and the flag
//   byte after the operation.
//   An accepted item is held in the input register, is evaluated
//   against the stored accumulator and flags and lands in the result
//   register. One item per cycle is sustained while rsp takes each result;
//   the accumulator/flag update is a single add plus flag logic closing
//   on itself in that one stage.
//   When rsp stalls, the held result and the input register stay put and
//   req_tready drops only when both are full.
//   Reset clears the accumulator, all flags and both valid bits.
//   Operation codes 18 to 31 change nothing and report the current state.
// ----------------------------------------------------------------------------
module i8080_alu_flags
   import i8080alu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] operand
   input  logic [4:0]  req_tuser,   // [4:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] acc_out, [15:8] flags_out
);

   logic       in_valid_ff;
   op_type     in_op_ff;
   logic [7:0] in_operand_ff;
   logic       rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic [7:0] acc_ff;
   flags_type  flag_ff;

   logic       advance;
   logic [7:0] acc_in;
   flags_type  flag_in;

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // evaluation
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic [4:0] add_low;
   logic [7:0] logic_res;
   logic [7:0] daa_corr;
   logic [8:0] daa_sum;
   logic [4:0] daa_low;
   logic       daa_cy;

   always_comb begin
      unique case (in_op_ff)
         OP_SUB, OP_CMP: begin
            add_b   = ~in_operand_ff;
            add_cin = 1'b1;
         end
         OP_SBB: begin
            add_b   = ~in_operand_ff;
            add_cin = ~flag_ff.c;
         end
         OP_ADC: begin
            add_b   = in_operand_ff;
            add_cin = flag_ff.c;
         end
         default: begin
            add_b   = in_operand_ff;
            add_cin = 1'b0;
         end
      endcase
      add_sum = {1'b0, acc_ff} + {1'b0, add_b} + {8'd0, add_cin};
      add_low = {1'b0, acc_ff[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};

      unique case (in_op_ff)
         OP_ANA:  logic_res = acc_ff & in_operand_ff;
         OP_XRA:  logic_res = acc_ff ^ in_operand_ff;
         default: logic_res = acc_ff | in_operand_ff;
      endcase

      // decimal adjust
      daa_corr = 8'd0;
      daa_cy   = flag_ff.c;
      if (flag_ff.ac || above_nine(acc_ff[3:0])) begin
         daa_corr[3:0] = LOW_ADJ;
      end
      if (flag_ff.c || above_nine(acc_ff[7:4]) ||
          (acc_ff[7:4] >= 4'h9 && above_nine(acc_ff[3:0]))) begin
         daa_corr = daa_corr | HIGH_ADJ;
         daa_cy   = 1'b1;
      end
      daa_sum = {1'b0, acc_ff} + {1'b0, daa_corr};
      daa_low = {1'b0, acc_ff[3:0]} + {1'b0, daa_corr[3:0]};

      acc_in  = acc_ff;
      flag_in = flag_ff;
      unique case (in_op_ff)
         OP_ADD, OP_ADC: begin
            acc_in     = add_sum[7:0];
            flag_in.c  = add_sum[8];
            flag_in.ac = add_low[4];
         end
         OP_SUB, OP_SBB, OP_CMP: begin
            if (in_op_ff != OP_CMP) begin
               acc_in = add_sum[7:0];
            end
            flag_in.c  = ~add_sum[8];
            flag_in.ac = add_low[4];
         end
         OP_ANA: begin
            acc_in     = logic_res;
            flag_in.c  = 1'b0;
            flag_in.ac = acc_ff[3] | in_operand_ff[3];
         end
         OP_XRA, OP_ORA: begin
            acc_in     = logic_res;
            flag_in.c  = 1'b0;
            flag_in.ac = 1'b0;
         end
         OP_RLC: begin
            acc_in    = {acc_ff[6:0], acc_ff[7]};
            flag_in.c = acc_ff[7];
         end
         OP_RRC: begin
            acc_in    = {acc_ff[0], acc_ff[7:1]};
            flag_in.c = acc_ff[0];
         end
         OP_RAL: begin
            acc_in    = {acc_ff[6:0], flag_ff.c};
            flag_in.c = acc_ff[7];
         end
         OP_RAR: begin
            acc_in    = {flag_ff.c, acc_ff[7:1]};
            flag_in.c = acc_ff[0];
         end
         OP_DAA: begin
            acc_in     = daa_sum[7:0];
            flag_in.c  = daa_cy;
            flag_in.ac = daa_low[4];
         end
         OP_CMA: acc_in = ~acc_ff;
         OP_STC: flag_in.c = 1'b1;
         OP_CMC: flag_in.c = ~flag_ff.c;
         OP_LDA: acc_in = in_operand_ff;
         OP_LDF: flag_in = byte_to_flags(in_operand_ff);
         default: ;
      endcase

      // sign, zero and parity follow the arithmetic, logic and decimal adjust result
      unique case (in_op_ff)
         OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP: begin
            flag_in.s = add_sum[7];
            flag_in.z = (add_sum[7:0] == 8'd0);
            flag_in.p = ~^add_sum[7:0];
         end
         OP_ANA, OP_XRA, OP_ORA, OP_DAA: begin
            flag_in.s = acc_in[7];
            flag_in.z = (acc_in == 8'd0);
            flag_in.p = ~^acc_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         flag_ff      <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
            flag_ff      <= flag_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff      <= op_type'(req_tuser);
         in_operand_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= {flags_to_byte(flag_in), acc_in};
      end
   end

   // assertions
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff == {flags_to_byte(flag_ff), acc_ff}))
      else $error("result register out of step with accumulator state");

   a_cmp_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_CMP) |=> (acc_ff == $past(acc_ff)))
      else $error("compare changed the accumulator");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled item dropped from input register");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(acc_ff) && $stable(flag_ff)))
      else $error("state changed without an item advancing");

endmodule
